// ----- src/bpa_pkg.sv -----
// Shared types and operation codes for the bump-pointer allocator.
package bpa_pkg;

    // Operation codes carried in the request type field.
    typedef enum logic [3:0] {
        REQ_ALLOC      = 4'd0,
        REQ_BUF_ALLOC  = 4'd1,
        REQ_ALIGN      = 4'd2,
        REQ_REWIND     = 4'd3,
        REQ_SET_RANGE  = 4'd4,
        REQ_EMPTY      = 4'd5,
        REQ_REBUILD    = 4'd6,
        REQ_RECALC     = 4'd7,
        REQ_SET_PTR    = 4'd8
    } t_req_code;

    // One request word as registered at the input.
    typedef struct packed {
        logic [3:0]  req_type;
        logic [31:0] request_size;
        logic [4:0]  align_log2;
        logic [31:0] address_low;
        logic [31:0] address_high;
    } t_req;

    // One result word.
    typedef struct packed {
        logic        ok;
        logic [31:0] grant_base;
        logic [31:0] grant_top;
        logic        free_entries;
        logic [31:0] largest_free;
        logic [31:0] free_memory;
    } t_res;

endpackage

// ----- src/bpa_in_reg.sv -----
// Input register stage: holds one request word until the execute step takes it.
module bpa_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  bpa_pkg::t_req i_req,
    input  logic          i_take,
    output logic          o_valid,
    output bpa_pkg::t_req o_req
);
    import bpa_pkg::*;

    logic r_vld;
    t_req r_req;

    // The stage is free when empty or when its word leaves in this cycle.
    assign o_stall = r_vld && !i_take;
    assign o_valid = r_vld;
    assign o_req   = r_req;

    // Valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!o_stall) begin
            r_vld <= i_valid;
        end
    end

    // Payload is loaded on every accepted word.
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_req <= i_req;
        end
    end

endmodule

// ----- src/bpa_exec.sv -----
// Allocator state and the combinational operation logic.
module bpa_exec #(
    parameter int ADDR_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_data,
    input  logic          i_fire,
    input  bpa_pkg::t_req i_req,
    output bpa_pkg::t_res o_res
);
    import bpa_pkg::*;

    localparam int AW = ADDR_BITS;
    localparam int CW = (ADDR_BITS > 32) ? ADDR_BITS : 32;

    logic [31:0]   r_min_free;
    logic [AW-1:0] r_alloc_ptr;
    logic [AW-1:0] r_top_ptr;
    logic          r_entry_count;
    logic [AW-1:0] r_largest;
    logic [AW-1:0] r_free_size;

    logic [AW-1:0] n_alloc_ptr;
    logic [AW-1:0] n_top_ptr;
    logic          n_entry_count;
    logic [AW-1:0] n_largest;
    logic [AW-1:0] n_free_size;

    logic [CW-1:0] lo_ext;
    logic [CW-1:0] hi_ext;
    logic [AW-1:0] lo_a;
    logic [AW-1:0] hi_a;
    logic [AW-1:0] rem;
    logic [CW-1:0] rem_c;
    logic [CW-1:0] size_c;
    logic [CW-1:0] min_c;
    logic [AW-1:0] grant;
    logic [AW-1:0] grant_end;
    logic [AW-1:0] rem_after;
    logic [CW-1:0] align_mask;
    logic [CW:0]   align_sum;
    logic [AW-1:0] aligned;
    logic [AW-1:0] stats_rem;
    logic          ok;
    logic [AW-1:0] base;
    logic [AW-1:0] gtop;

    // Operand preparation: addresses masked to the pointer width.
    always_comb begin
        lo_ext     = CW'(i_req.address_low);
        hi_ext     = CW'(i_req.address_high);
        lo_a       = lo_ext[AW-1:0];
        hi_a       = hi_ext[AW-1:0];
        rem        = (r_alloc_ptr < r_top_ptr) ? (r_top_ptr - r_alloc_ptr) : '0;
        rem_c      = CW'(rem);
        size_c     = CW'(i_req.request_size);
        min_c      = CW'(r_min_free);
        align_mask = CW'((33'd1 << i_req.align_log2) - 33'd1);
        align_sum  = {1'b0, CW'(r_alloc_ptr)} + {1'b0, align_mask};
        aligned    = align_sum[AW-1:0] & ~align_mask[AW-1:0];
    end

    // Operation decode and next state.
    always_comb begin
        n_alloc_ptr   = r_alloc_ptr;
        n_top_ptr     = r_top_ptr;
        n_entry_count = r_entry_count;
        n_largest     = r_largest;
        n_free_size   = r_free_size;
        ok            = 1'b0;
        base          = '0;
        gtop          = '0;
        grant         = '0;
        grant_end     = '0;
        rem_after     = '0;
        stats_rem     = '0;
        unique case (i_req.req_type)
            REQ_ALLOC: begin
                grant     = size_c[AW-1:0];
                grant_end = r_alloc_ptr + grant;
                rem_after = rem - grant;
                if (size_c <= rem_c) begin
                    ok            = 1'b1;
                    base          = r_alloc_ptr;
                    gtop          = grant_end;
                    n_alloc_ptr   = grant_end;
                    n_entry_count = (rem_after != '0);
                    n_largest     = rem_after;
                end
            end
            REQ_BUF_ALLOC: begin
                grant     = (size_c < rem_c) ? size_c[AW-1:0] : rem;
                grant_end = r_alloc_ptr + grant;
                rem_after = rem - grant;
                if (min_c <= rem_c) begin
                    ok   = 1'b1;
                    base = r_alloc_ptr;
                    // A remainder too small to keep is folded into the grant.
                    if (CW'(rem_after) < min_c) begin
                        gtop          = r_top_ptr;
                        n_alloc_ptr   = r_top_ptr;
                        n_entry_count = 1'b0;
                        n_largest     = '0;
                    end else begin
                        gtop          = grant_end;
                        n_alloc_ptr   = grant_end;
                        n_entry_count = 1'b1;
                        n_largest     = rem_after;
                    end
                end
            end
            REQ_ALIGN: begin
                if (r_alloc_ptr < r_top_ptr) begin
                    // Rounding past the address space clamps to top.
                    if (align_sum[CW:AW] != '0) begin
                        n_alloc_ptr = r_top_ptr;
                    end else begin
                        n_alloc_ptr = (aligned < r_top_ptr) ? aligned : r_top_ptr;
                    end
                end
            end
            REQ_REWIND: begin
                if (lo_a < r_alloc_ptr) begin
                    n_alloc_ptr = lo_a;
                    ok          = 1'b1;
                end
            end
            REQ_SET_RANGE: begin
                n_alloc_ptr   = lo_a;
                n_top_ptr     = hi_a;
                stats_rem     = (lo_a < hi_a) ? (hi_a - lo_a) : '0;
                n_entry_count = 1'b1;
                n_largest     = stats_rem;
                n_free_size   = stats_rem;
            end
            REQ_EMPTY: begin
                n_alloc_ptr = r_top_ptr;
            end
            REQ_REBUILD: begin
                n_alloc_ptr   = lo_a;
                stats_rem     = (lo_a < r_top_ptr) ? (r_top_ptr - lo_a) : '0;
                n_entry_count = 1'b1;
                n_largest     = stats_rem;
                n_free_size   = stats_rem;
            end
            REQ_RECALC: begin
                n_entry_count = 1'b1;
                n_largest     = rem;
                n_free_size   = rem;
            end
            REQ_SET_PTR: begin
                n_alloc_ptr = lo_a;
            end
            default: begin
            end
        endcase
    end

    // Result word, fields cut to their output widths.
    always_comb begin
        o_res.ok           = ok;
        o_res.grant_base   = 32'(CW'(base));
        o_res.grant_top    = 32'(CW'(gtop));
        o_res.free_entries = n_entry_count;
        o_res.largest_free = 32'(CW'(n_largest));
        o_res.free_memory  = 32'(CW'(n_free_size));
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_free    <= '0;
            r_alloc_ptr   <= '0;
            r_top_ptr     <= '0;
            r_entry_count <= 1'b0;
            r_largest     <= '0;
            r_free_size   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_min_free <= i_cfg_data;
            end
            if (i_fire) begin
                r_alloc_ptr   <= n_alloc_ptr;
                r_top_ptr     <= n_top_ptr;
                r_entry_count <= n_entry_count;
                r_largest     <= n_largest;
                r_free_size   <= n_free_size;
            end
        end
    end

endmodule

// ----- src/bpa_out_reg.sv -----
// Result register: holds one result word until the consumer takes it.
module bpa_out_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  bpa_pkg::t_res i_res,
    input  logic          i_stall,
    output logic          o_free,
    output logic          o_valid,
    output bpa_pkg::t_res o_res
);
    import bpa_pkg::*;

    logic r_vld;
    t_res r_res;

    // A new word may enter when the register is empty or is being read.
    assign o_free  = !r_vld || !i_stall;
    assign o_valid = r_vld;
    assign o_res   = r_res;

    // Valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_free) begin
            r_vld <= i_load;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_res <= i_res;
        end
    end

endmodule

// ----- src/bump_pointer_allocator_core.sv -----
// Top level of the bump-pointer region allocator.
//
//  Channel   Direction  Handshake              Word
//  in        input      i_in_valid/o_in_stall  request type, size, alignment, bounds
//  out       output     o_out_valid/i_out_stall  ok, grant, free statistics
//  cfg       input      i_cfg_valid/o_cfg_ready  minimum free entry size
//
// One word per cycle is sustained while the consumer does not stall; a request is held
// first in the input register and then in the result register, which drives the outputs.
// The operation itself is a single subtract, compare and add pass on the state.
// Reset is synchronous and active low; it clears both stage valid bits and all allocator state.
// Input stalls only while the result register is full and the consumer stalls.
module bump_pointer_allocator_core #(
    parameter int ADDR_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_req_type,
    input  logic [31:0] i_request_size,
    input  logic [4:0]  i_align_log2,
    input  logic [31:0] i_address_low,
    input  logic [31:0] i_address_high,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_ok,
    output logic [31:0] o_grant_base,
    output logic [31:0] o_grant_top,
    output logic        o_free_entries,
    output logic [31:0] o_largest_free,
    output logic [31:0] o_free_memory,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
    import bpa_pkg::*;

    t_req in_req;
    t_req req_q;
    t_res res_d;
    t_res res_q;
    logic req_vld;
    logic out_free;
    logic fire;

    // Pack the input fields into one word.
    always_comb begin
        in_req.req_type     = i_req_type;
        in_req.request_size = i_request_size;
        in_req.align_log2   = i_align_log2;
        in_req.address_low  = i_address_low;
        in_req.address_high = i_address_high;
    end

    // A request executes when it moves into the result register.
    assign fire        = req_vld && out_free;
    assign o_cfg_ready = 1'b1;

    bpa_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_req   (in_req),
        .i_take  (fire),
        .o_valid (req_vld),
        .o_req   (req_q)
    );

    bpa_exec #(
        .ADDR_BITS (ADDR_BITS)
    ) u_exec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_fire     (fire),
        .i_req      (req_q),
        .o_res      (res_d)
    );

    bpa_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (req_vld),
        .i_res   (res_d),
        .i_stall (i_out_stall),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_res   (res_q)
    );

    // Unpack the result word.
    assign o_ok           = res_q.ok;
    assign o_grant_base   = res_q.grant_base;
    assign o_grant_top    = res_q.grant_top;
    assign o_free_entries = res_q.free_entries;
    assign o_largest_free = res_q.largest_free;
    assign o_free_memory  = res_q.free_memory;

endmodule

// ----- src/bpa_checker.sv -----
// Port-level checks for the allocator top level, bound to it.
module bpa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_ok,
    input logic [31:0] o_grant_base,
    input logic [31:0] o_grant_top,
    input logic        o_free_entries,
    input logic [31:0] o_largest_free
);

    // A stalled result word holds its grant fields.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(o_grant_base) && $stable(o_grant_top)))
        else $error("stalled result word changed");

    // Every accepted request is followed by a valid result word at the outputs.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> ##2 o_out_valid)
        else $error("accepted request produced no result");

    // The input only stalls behind a full, stalled result register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without back pressure");

    // Results that are not grants carry no addresses.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ok) |-> (o_grant_base == 32'd0 && o_grant_top == 32'd0))
        else $error("failed request carries a grant");

    // No free entry means no largest free size.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_free_entries) |-> (o_largest_free == 32'd0))
        else $error("largest free size without a free entry");

endmodule

bind bump_pointer_allocator_core bpa_checker u_bpa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_ok           (o_ok),
    .o_grant_base   (o_grant_base),
    .o_grant_top    (o_grant_top),
    .o_free_entries (o_free_entries),
    .o_largest_free (o_largest_free)
);
